// File: hw/rtl/ecm_pkg.sv
// Shared constants, field widths and unit request/response types for the
// equity curve metrics block. No dependencies.
`timescale 1ns / 1ps

package ecm_pkg;

    localparam int EQUITY_BITS = 48;
    localparam int EQ_W        = 48;
    localparam int OUT_W       = 32;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = 64;
    localparam int DIV_W       = 64;
    localparam int DIV_Q_W     = 80;
    localparam int DIV_CNT_W   = 7;
    localparam int EQ_ALIGN    = DIV_W - EQ_W;

    localparam logic [EQ_W-1:0] EQ_MASK = EQ_W'((65'd1 << EQUITY_BITS) - 65'd1);

    // Iteration counts: significant dividend bits plus fraction bits
    localparam logic [DIV_CNT_W-1:0] DD_ITERS   = DIV_CNT_W'(EQ_W + 31);
    localparam logic [DIV_CNT_W-1:0] RET_ITERS  = DIV_CNT_W'(EQ_W + 32);
    localparam logic [DIV_CNT_W-1:0] RATE_ITERS = DIV_CNT_W'(EQ_W + 16);
    localparam logic [DIV_CNT_W-1:0] SUM_ITERS  = DIV_CNT_W'(DIV_W);
    localparam logic [DIV_CNT_W-1:0] SH_ITERS   = DIV_CNT_W'(DIV_W + 8);

    localparam logic [DIV_W-1:0] LIM_DD      = 64'h0000_0000_8000_0000;
    localparam logic [DIV_W-1:0] LIM_RET_NEG = 64'h0000_0080_0000_0000;
    localparam logic [DIV_W-1:0] LIM_RET_POS = 64'h0000_007F_FFFF_FFFF;
    localparam logic [DIV_W-1:0] LIM_S32_NEG = 64'h0000_0000_8000_0000;
    localparam logic [DIV_W-1:0] LIM_S32_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [DIV_W-1:0] LIM_NONE    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     num;    // MSB-aligned dividend
        logic [DIV_W-1:0]     den;
        logic [DIV_CNT_W-1:0] iters;
        logic [DIV_W-1:0]     limit;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// File: hw/rtl/ecm_if.sv
// Channel interfaces: sample input, result output and configuration write.
// Depends on ecm_pkg for field widths.
`timescale 1ns / 1ps

interface ecm_sample_if;
    logic                     valid;
    logic                     ready;
    logic [ecm_pkg::EQ_W-1:0] equity;
    logic                     last;
    modport source (output valid, equity, last, input ready);
    modport sink   (input valid, equity, last, output ready);
endinterface

interface ecm_result_if;
    logic                      valid;
    logic                      ready;
    logic [ecm_pkg::EQ_W-1:0]  end_equity;
    logic [ecm_pkg::OUT_W-1:0] total_return;
    logic [ecm_pkg::OUT_W-1:0] peak_drop;
    logic [ecm_pkg::OUT_W-1:0] risk_ratio;
    logic [ecm_pkg::CNT_W-1:0] sample_count;
    logic                      divide_fault;
    modport source (output valid, end_equity, total_return, peak_drop, risk_ratio,
                    sample_count, divide_fault, input ready);
    modport sink   (input valid, end_equity, total_return, peak_drop, risk_ratio,
                    sample_count, divide_fault, output ready);
endinterface

interface ecm_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [ecm_pkg::EQ_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/ecm_div.sv
// Shared serial divider: one quotient bit per cycle, result saturated to a limit.
// Depends on ecm_pkg for the request and response types.
`timescale 1ns / 1ps

module ecm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ecm_pkg::div_req_t req,
    output ecm_pkg::div_rsp_t rsp
);
    import ecm_pkg::*;

    logic [DIV_W-1:0]     num_reg, den_reg, rem_reg, limit_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;

    logic [DIV_W:0]       shifted;
    logic                 fits;
    logic [DIV_W-1:0]     rem_step;

    always_comb
    begin
        shifted  = {rem_reg, num_reg[DIV_W-1]};
        fits     = shifted >= {1'b0, den_reg};
        rem_step = fits ? DIV_W'(shifted - {1'b0, den_reg}) : shifted[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg   <= req.num;
            den_reg   <= req.den;
            limit_reg <= req.limit;
            rem_reg   <= '0;
            q_reg     <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_W-2:0], 1'b0};
            rem_reg <= rem_step;
            q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = (q_reg > {{(DIV_Q_W-DIV_W){1'b0}}, limit_reg}) ? limit_reg
                                                                    : q_reg[DIV_W-1:0];

endmodule

// File: hw/rtl/ecm_sqrt.sv
// Serial floor square root of a 64-bit value, one result bit per cycle.
// Depends on ecm_pkg for the request and response types.
`timescale 1ns / 1ps

module ecm_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  ecm_pkg::sqrt_req_t req,
    output ecm_pkg::sqrt_rsp_t rsp
);
    import ecm_pkg::*;

    logic [DIV_W-1:0] v_reg, res_reg, bit_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg, done_reg;

    logic [DIV_W-1:0] trial;
    logic             take;

    always_comb
    begin
        trial = res_reg + bit_reg;
        take  = v_reg >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            v_reg   <= req.radicand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[OUT_W-1:0];

endmodule

// File: hw/rtl/equity_curve_metrics_core.sv
// Equity curve metrics: drawdown, return and Sharpe ratio over one run.
// Depends on ecm_pkg, ecm_if, ecm_div and ecm_sqrt.
//
//   channel  dir  transfer carries
//   -------  ---  ------------------------------------------------------------
//   sample   in   equity, last
//   result   out  end_equity, total_return, peak_drop, risk_ratio,
//                 sample_count, divide_fault
//   cfg      in   data (initial equity)
//
// A sample after the first of a run runs two serial divides (drawdown, then
// return), the squarer in states S_SQ0 to S_SQ3, and the updates. A last
// sample adds a rate divide, mean and mean-square divides, the squarer, a
// serial root and a Sharpe divide.
// All divides share the one serial divider, one quotient bit per cycle.
// Reset clears all run state and the initial equity; a waiting result does not
// block the next samples until that run's own result is ready.
`timescale 1ns / 1ps

module equity_curve_metrics_core (
    input  logic clk,
    input  logic rst_n,
    ecm_sample_if.sink   sample,
    ecm_result_if.source result,
    ecm_cfg_if.sink      cfg
);
    import ecm_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DD_GO    = 5'd1;
    localparam logic [4:0] S_DD_WAIT  = 5'd2;
    localparam logic [4:0] S_RET_GO   = 5'd3;
    localparam logic [4:0] S_RET_WAIT = 5'd4;
    localparam logic [4:0] S_SQ0      = 5'd5;
    localparam logic [4:0] S_SQ1      = 5'd6;
    localparam logic [4:0] S_SQ2      = 5'd7;
    localparam logic [4:0] S_SQ3      = 5'd8;
    localparam logic [4:0] S_ACC      = 5'd9;
    localparam logic [4:0] S_FIN      = 5'd10;
    localparam logic [4:0] S_RATE_W   = 5'd11;
    localparam logic [4:0] S_STAT     = 5'd12;
    localparam logic [4:0] S_MEAN_W   = 5'd13;
    localparam logic [4:0] S_MSQ_GO   = 5'd14;
    localparam logic [4:0] S_MSQ_W    = 5'd15;
    localparam logic [4:0] S_VAR      = 5'd16;
    localparam logic [4:0] S_SQRT_W   = 5'd17;
    localparam logic [4:0] S_SH_GO    = 5'd18;
    localparam logic [4:0] S_SH_W     = 5'd19;
    localparam logic [4:0] S_OUT      = 5'd20;

    logic [4:0]       state_reg, state_next;
    logic [EQ_W-1:0]  e_reg, e_next;
    logic             last_reg, last_next;
    logic [EQ_W-1:0]  init_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [EQ_W-1:0]  prev_reg, prev_next, peak_reg, peak_next;
    logic [OUT_W-1:0] worst_reg, worst_next;
    logic [SUM_W-1:0] sum_reg, sum_next, sqsum_reg, sqsum_next;
    logic             fault_reg, fault_next;
    logic             sq_mean_reg, sq_mean_next;
    logic [39:0]      mag_reg, mag_next;
    logic [SUM_W-1:0] mean_reg, mean_next, meansq_reg, meansq_next;
    logic [SUM_W-1:0] prod_reg, prod_next, acc_reg, acc_next;
    logic [OUT_W-1:0] sd_reg, sd_next, rate_reg, rate_next, sharpe_reg, sharpe_next;

    logic             out_valid_reg;
    logic [EQ_W-1:0]  out_equity_reg;
    logic [OUT_W-1:0] out_rate_reg, out_dd_reg, out_sharpe_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_fault_reg;
    logic             out_load;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    logic             in_xfer, out_xfer;
    logic [SUM_W-1:0] sq_src;
    logic [31:0]      mul_a, mul_b;
    logic             ret_neg, rate_neg, sum_neg;
    logic [EQ_W-1:0]  ret_diff, rate_diff;
    logic [SUM_W-1:0] r64, smag, var_full;
    logic [SUM_W:0]   sum65, sq65;
    logic [EQ_W-1:0]  var_clamp;
    logic [CNT_W-1:0] n_ret;

    assign in_xfer  = sample.valid && sample.ready;
    assign out_xfer = result.valid && result.ready;
    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;

    ecm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ecm_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    always_comb
    begin
        ret_neg   = e_reg < prev_reg;
        ret_diff  = ret_neg ? prev_reg - e_reg : e_reg - prev_reg;
        rate_neg  = e_reg < init_reg;
        rate_diff = rate_neg ? init_reg - e_reg : e_reg - init_reg;
        sum_neg   = sum_reg[SUM_W-1];
        smag      = sum_neg ? SUM_W'(0) - sum_reg : sum_reg;
        n_ret     = count_reg - 1'b1;
        sq_src    = sq_mean_reg ? mean_reg : {24'b0, mag_reg};
        r64       = ret_neg ? SUM_W'(0) - {24'b0, mag_reg} : {24'b0, mag_reg};
        sum65     = {sum_reg[SUM_W-1], sum_reg} + {r64[SUM_W-1], r64};
        sq65      = {1'b0, sqsum_reg} + {1'b0, acc_reg};
        var_full  = (meansq_reg > acc_reg) ? meansq_reg - acc_reg : '0;
        var_clamp = (|var_full[SUM_W-1:EQ_W]) ? {EQ_W{1'b1}} : var_full[EQ_W-1:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        e_next       = e_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        prev_next    = prev_reg;
        peak_next    = peak_reg;
        worst_next   = worst_reg;
        sum_next     = sum_reg;
        sqsum_next   = sqsum_reg;
        fault_next   = fault_reg;
        sq_mean_next = sq_mean_reg;
        mag_next     = mag_reg;
        mean_next    = mean_reg;
        meansq_next  = meansq_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        sd_next      = sd_reg;
        rate_next    = rate_reg;
        sharpe_next  = sharpe_reg;
        out_load     = 1'b0;
        mul_a        = sq_src[31:0];
        mul_b        = sq_src[31:0];
        div_req      = '0;
        sqrt_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    e_next    = sample.equity & EQ_MASK;
                    last_next = sample.last;
                    if (count_reg == '0)
                    begin
                        prev_next  = sample.equity & EQ_MASK;
                        peak_next  = sample.equity & EQ_MASK;
                        count_next = CNT_W'(1);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        if ((sample.equity & EQ_MASK) > peak_reg)
                        begin
                            peak_next = sample.equity & EQ_MASK;
                        end
                        state_next = S_DD_GO;
                    end
                end
            end
            S_DD_GO:
            begin
                if (peak_reg == '0)
                begin
                    fault_next = 1'b1;
                    state_next = S_RET_GO;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {peak_reg - e_reg, {EQ_ALIGN{1'b0}}};
                    div_req.den   = {{EQ_ALIGN{1'b0}}, peak_reg};
                    div_req.iters = DD_ITERS;
                    div_req.limit = LIM_DD;
                    state_next    = S_DD_WAIT;
                end
            end
            S_DD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quo[OUT_W-1:0] > worst_reg)
                    begin
                        worst_next = div_rsp.quo[OUT_W-1:0];
                    end
                    state_next = S_RET_GO;
                end
            end
            S_RET_GO:
            begin
                sq_mean_next = 1'b0;
                if (prev_reg == '0)
                begin
                    fault_next = 1'b1;
                    mag_next   = '0;
                    state_next = S_SQ0;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {ret_diff, {EQ_ALIGN{1'b0}}};
                    div_req.den   = {{EQ_ALIGN{1'b0}}, prev_reg};
                    div_req.iters = RET_ITERS;
                    div_req.limit = ret_neg ? LIM_RET_NEG : LIM_RET_POS;
                    state_next    = S_RET_WAIT;
                end
            end
            S_RET_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mag_next   = div_rsp.quo[39:0];
                    state_next = S_SQ0;
                end
            end
            // (a * a) >> 32 from three 32-bit partial products, modulo 2^64
            S_SQ0:
            begin
                prod_next  = {32'b0, mul_a} * {32'b0, mul_b};
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                mul_a      = sq_src[63:32];
                acc_next   = {32'b0, prod_reg[63:32]};
                prod_next  = {32'b0, mul_a} * {32'b0, mul_b};
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                mul_a      = sq_src[63:32];
                mul_b      = sq_src[63:32];
                acc_next   = acc_reg + {prod_reg[62:0], 1'b0};
                prod_next  = {32'b0, mul_a} * {32'b0, mul_b};
                state_next = S_SQ3;
            end
            S_SQ3:
            begin
                acc_next   = acc_reg + {prod_reg[31:0], 32'b0};
                state_next = sq_mean_reg ? S_VAR : S_ACC;
            end
            S_ACC:
            begin
                if (sum65[SUM_W] != sum65[SUM_W-1])
                begin
                    sum_next = sum65[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
                end
                else
                begin
                    sum_next = sum65[SUM_W-1:0];
                end
                sqsum_next = sq65[SUM_W] ? {SUM_W{1'b1}} : sq65[SUM_W-1:0];
                prev_next  = e_reg;
                if (count_reg != {CNT_W{1'b1}})
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                rate_next = '0;
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (init_reg == '0)
                begin
                    fault_next = 1'b1;
                    state_next = S_STAT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {rate_diff, {EQ_ALIGN{1'b0}}};
                    div_req.den   = {{EQ_ALIGN{1'b0}}, init_reg};
                    div_req.iters = RATE_ITERS;
                    div_req.limit = rate_neg ? LIM_S32_NEG : LIM_S32_POS;
                    state_next    = S_RATE_W;
                end
            end
            S_RATE_W:
            begin
                if (div_rsp.done)
                begin
                    rate_next  = rate_neg ? OUT_W'(0) - div_rsp.quo[OUT_W-1:0]
                                          : div_rsp.quo[OUT_W-1:0];
                    state_next = S_STAT;
                end
            end
            S_STAT:
            begin
                sharpe_next = '0;
                if (count_reg >= CNT_W'(2))
                begin
                    div_req.start = 1'b1;
                    div_req.num   = smag;
                    div_req.den   = {32'b0, n_ret};
                    div_req.iters = SUM_ITERS;
                    div_req.limit = LIM_NONE;
                    state_next    = S_MEAN_W;
                end
                else
                begin
                    worst_next = '0;
                    state_next = S_OUT;
                end
            end
            S_MEAN_W:
            begin
                if (div_rsp.done)
                begin
                    mean_next  = div_rsp.quo;
                    state_next = S_MSQ_GO;
                end
            end
            S_MSQ_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = sqsum_reg;
                div_req.den   = {32'b0, n_ret};
                div_req.iters = SUM_ITERS;
                div_req.limit = LIM_NONE;
                state_next    = S_MSQ_W;
            end
            S_MSQ_W:
            begin
                if (div_rsp.done)
                begin
                    meansq_next  = div_rsp.quo;
                    sq_mean_next = 1'b1;
                    state_next   = S_SQ0;
                end
            end
            S_VAR:
            begin
                sqrt_req.start    = 1'b1;
                sqrt_req.radicand = {var_clamp, 16'b0};
                state_next        = S_SQRT_W;
            end
            S_SQRT_W:
            begin
                if (sqrt_rsp.done)
                begin
                    sd_next    = sqrt_rsp.root;
                    state_next = S_SH_GO;
                end
            end
            S_SH_GO:
            begin
                if (sd_reg == '0)
                begin
                    fault_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = mean_reg;
                    div_req.den   = {32'b0, sd_reg};
                    div_req.iters = SH_ITERS;
                    div_req.limit = sum_neg ? LIM_S32_NEG : LIM_S32_POS;
                    state_next    = S_SH_W;
                end
            end
            S_SH_W:
            begin
                if (div_rsp.done)
                begin
                    sharpe_next = sum_neg ? OUT_W'(0) - div_rsp.quo[OUT_W-1:0]
                                          : div_rsp.quo[OUT_W-1:0];
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free, then clear the run
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    count_next = '0;
                    prev_next  = '0;
                    peak_next  = '0;
                    worst_next = '0;
                    sum_next   = '0;
                    sqsum_next = '0;
                    fault_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_reg      <= '0;
            count_reg     <= '0;
            prev_reg      <= '0;
            peak_reg      <= '0;
            worst_reg     <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            fault_reg     <= 1'b0;
            sq_mean_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            prev_reg    <= prev_next;
            peak_reg    <= peak_next;
            worst_reg   <= worst_next;
            sum_reg     <= sum_next;
            sqsum_reg   <= sqsum_next;
            fault_reg   <= fault_next;
            sq_mean_reg <= sq_mean_next;
            if (cfg.valid && cfg.ready)
            begin
                init_reg <= cfg.data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        last_reg   <= last_next;
        mag_reg    <= mag_next;
        mean_reg   <= mean_next;
        meansq_reg <= meansq_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        sd_reg     <= sd_next;
        rate_reg   <= rate_next;
        sharpe_reg <= sharpe_next;
        if (out_load)
        begin
            out_equity_reg <= e_reg;
            out_rate_reg   <= rate_reg;
            out_dd_reg     <= worst_reg;
            out_sharpe_reg <= sharpe_reg;
            out_count_reg  <= count_reg;
            out_fault_reg  <= fault_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.end_equity   = out_equity_reg;
    assign result.total_return = out_rate_reg;
    assign result.peak_drop    = out_dd_reg;
    assign result.risk_ratio   = out_sharpe_reg;
    assign result.sample_count = out_count_reg;
    assign result.divide_fault = out_fault_reg;

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DD_WAIT || state_reg == S_RET_WAIT ||
                          state_reg == S_RATE_W || state_reg == S_MEAN_W ||
                          state_reg == S_MSQ_W || state_reg == S_SH_W))
        else $error("divider finished outside a wait state");

    a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_rsp.done |-> (state_reg == S_SQRT_W))
        else $error("root finished outside its wait state");

    a_first_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && count_reg == '0) |=> (count_reg == CNT_W'(1) && peak_reg == prev_reg))
        else $error("first sample did not seed the run");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_valid_reg) |=> (out_valid_reg && count_reg == '0))
        else $error("result not loaded or run not cleared");

    a_dd_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.peak_drop <= 32'h8000_0000))
        else $error("drawdown out of range");

endmodule
